// ----- rtl/cewd_pkg.sv -----
// Shared types, constants and helper functions of the clock evidence age watchdog.
package cewd_pkg;

	localparam int unsigned TIME_W     = 63;
	localparam logic [TIME_W-1:0] MAX63 = '1;

	localparam int unsigned NS_PER_MS  = 1_000_000;
	// 1e6 = 2^6 * 15625: the low six bits are dropped and the rest is divided by 15625.
	localparam int unsigned DIV_SHIFT  = 6;
	localparam int unsigned DIV_CONST  = NS_PER_MS >> DIV_SHIFT;
	localparam int unsigned X_W        = TIME_W - DIV_SHIFT;
	localparam int unsigned REM_W      = 14;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned PART_W     = REM_W + DIGIT_W;
	localparam int unsigned THR_W      = 45;
	localparam int unsigned NUM_W      = 48;
	localparam int unsigned QUO_W      = 32;
	localparam int unsigned DIV_STAGES = NUM_W / (2 * DIGIT_W);

	localparam logic [TIME_W-1:0] RTO_RESET = 63'd1_000_000_000;
	localparam logic [TIME_W-1:0] EL_RESET  = 63'd5_000_000_000;
	localparam logic [TIME_W-1:0] NTO_RESET = 63'd10_000_000_000;

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CHECK  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_ARG = 2'd1,
		ST_CFG_BAD = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_DEGRADED = 2'd1,
		EV_EXPIRED  = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		WM_ZERO = 2'd0,
		WM_CAP  = 2'd1,
		WM_ONE  = 2'd2,
		WM_DIV  = 2'd3
	} wait_mode_t;

	typedef enum logic [1:0] {
		CFG_REPORT_TIMEOUT = 2'd0,
		CFG_EXTRAP_LIMIT   = 2'd1,
		CFG_NAME_TIMEOUT   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		status_t            status;
		event_t             age_event;
		logic               dl_valid;
		logic [TIME_W-1:0]  dl;
	} res_t;

	typedef struct packed {
		res_t               res;
		wait_mode_t         wmode;
		logic [TIME_W-1:0]  now;
	} eval_t;

	typedef struct packed {
		res_t               res;
		wait_mode_t         wmode;
		logic [30:0]        cap;
		logic [NUM_W-1:0]   num;
		logic [REM_W-1:0]   rem;
		logic [QUO_W-1:0]   quo;
	} div_stage_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] d;
		logic [REM_W-1:0]   rem;
	} digit_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
			input logic [TIME_W-1:0] iv);
		logic [TIME_W:0] s;
		s = {1'b0, t} + {1'b0, iv};
		return s[TIME_W] ? MAX63 : s[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] min63(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	// One radix-16 long-division digit by DIV_CONST; the incoming remainder is below DIV_CONST.
	function automatic digit_t div_digit(input logic [REM_W-1:0] rem,
			input logic [DIGIT_W-1:0] nib);
		logic [PART_W-1:0]  part;
		logic [DIGIT_W-1:0] d;
		digit_t             r;
		part = {rem, nib};
		d    = '0;
		for (int k = 1; k < (1 << DIGIT_W); k++) begin
			if (part >= PART_W'(k * DIV_CONST)) d = DIGIT_W'(k);
		end
		r.d   = d;
		r.rem = REM_W'(part - PART_W'(d * DIV_CONST));
		return r;
	endfunction

endpackage

// ----- rtl/cewd_if.sv -----
// Command and result channel interfaces of the clock evidence age watchdog.
interface cewd_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [63:0] report_time_ns;
	logic signed [63:0] name_time_ns;
	logic signed [63:0] now_ns;
	logic signed [31:0] wait_cap_ms;

	modport source (output valid, operation, report_time_ns, name_time_ns, now_ns,
		wait_cap_ms, input ready);
	modport sink (input valid, operation, report_time_ns, name_time_ns, now_ns,
		wait_cap_ms, output ready);
endinterface

interface cewd_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [30:0] wait_ms;
	logic [1:0]  age_event;
	logic        deadline_valid;
	logic [62:0] deadline_ns;

	modport source (output valid, status, wait_ms, age_event, deadline_valid, deadline_ns,
		input ready);
	modport sink (input valid, status, wait_ms, age_event, deadline_valid, deadline_ns,
		output ready);
endinterface

// ----- rtl/cewd_eval.sv -----
// Configuration registers, evidence state and the per-command decision logic.
module cewd_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                write_en,
	input  logic [1:0]          reg_index,
	input  logic [62:0]         write_data,
	input  cewd_pkg::op_t       op,
	input  logic signed [63:0]  report_time_ns,
	input  logic signed [63:0]  name_time_ns,
	input  logic signed [63:0]  now_ns,
	input  logic signed [31:0]  wait_cap_ms,
	input  logic                commit,
	output cewd_pkg::eval_t     result
);
	import cewd_pkg::*;

	logic [TIME_W-1:0] rto_q, el_q, nto_q;
	logic              held_q, degr_q, exp_q;
	logic [TIME_W-1:0] rs_q, ns_q;

	logic              held_d, degr_d, exp_d;
	logic [TIME_W-1:0] rs_d, ns_d;

	logic              ordered, now_neg, cap_bad;
	logic [TIME_W-1:0] now_u;
	logic [TIME_W-1:0] a_rt, a_el, b_nm, m_rt, m_el, cur_dl, rec_a, rec_b;
	logic              cur_dv, late, name_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rto_q <= RTO_RESET;
			el_q  <= EL_RESET;
			nto_q <= NTO_RESET;
		end else if (write_en) begin
			unique case (reg_index)
				CFG_REPORT_TIMEOUT: rto_q <= write_data;
				CFG_EXTRAP_LIMIT:   el_q  <= write_data;
				CFG_NAME_TIMEOUT:   nto_q <= write_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ordered  = (rto_q != '0) && (el_q > rto_q) && (nto_q != '0);
		now_neg  = now_ns[63];
		now_u    = now_ns[TIME_W-1:0];
		cap_bad  = wait_cap_ms[31] || (wait_cap_ms == '0);

		a_rt     = sat_add(rs_q, rto_q);
		a_el     = sat_add(rs_q, el_q);
		b_nm     = sat_add(ns_q, nto_q);
		m_rt     = min63(a_rt, b_nm);
		m_el     = min63(a_el, b_nm);
		cur_dv   = held_q && !exp_q;
		cur_dl   = degr_q ? m_el : m_rt;
		// Past the minimum of two deadlines means past either one of them.
		late     = cur_dv && ((now_u > (degr_q ? a_el : a_rt)) || (now_u > b_nm));
		name_out = now_u >= b_nm;

		rec_a    = sat_add(report_time_ns[TIME_W-1:0], rto_q);
		rec_b    = sat_add(name_time_ns[TIME_W-1:0], nto_q);

		held_d = held_q;
		degr_d = degr_q;
		exp_d  = exp_q;
		rs_d   = rs_q;
		ns_d   = ns_q;

		result.res.status    = ST_OK;
		result.res.age_event = EV_NONE;
		result.res.dl_valid  = cur_dv;
		result.res.dl        = cur_dv ? cur_dl : '0;
		result.wmode         = WM_ZERO;
		result.now           = now_u;

		if (op != OP_CLEAR && !ordered) begin
			result.res.status = ST_CFG_BAD;
		end else begin
			unique case (op)
				OP_CLEAR: begin
					held_d = 1'b0;
					degr_d = 1'b0;
					exp_d  = 1'b0;
					rs_d   = '0;
					ns_d   = '0;
					result.res.dl_valid = 1'b0;
					result.res.dl       = '0;
				end
				OP_RECORD: begin
					if (report_time_ns[63] || name_time_ns[63]) begin
						result.res.status = ST_BAD_ARG;
					end else begin
						held_d = 1'b1;
						degr_d = 1'b0;
						exp_d  = 1'b0;
						rs_d   = report_time_ns[TIME_W-1:0];
						ns_d   = name_time_ns[TIME_W-1:0];
						result.res.dl_valid = 1'b1;
						result.res.dl       = min63(rec_a, rec_b);
					end
				end
				OP_QUERY: begin
					if (now_neg || cap_bad) result.res.status = ST_BAD_ARG;
					else if (!cur_dv) result.wmode = WM_CAP;
					else if (cur_dl <= now_u) result.wmode = WM_ONE;
					else result.wmode = WM_DIV;
				end
				OP_CHECK: begin
					if (now_neg) begin
						result.res.status = ST_BAD_ARG;
					end else if (late) begin
						if (name_out || degr_q) begin
							exp_d = 1'b1;
							result.res.age_event = EV_EXPIRED;
							result.res.dl_valid  = 1'b0;
							result.res.dl        = '0;
						end else begin
							degr_d = 1'b1;
							result.res.age_event = EV_DEGRADED;
							result.res.dl_valid  = 1'b1;
							result.res.dl        = m_el;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			degr_q <= 1'b0;
			exp_q  <= 1'b0;
			rs_q   <= '0;
			ns_q   <= '0;
		end else if (commit) begin
			held_q <= held_d;
			degr_q <= degr_d;
			exp_q  <= exp_d;
			rs_q   <= rs_d;
			ns_q   <= ns_d;
		end
	end

endmodule

// ----- rtl/clock_evidence_age_watchdog_core.sv -----
// Top level of the clock evidence age watchdog: command pipeline and wait divider.
//
// Commands arrive on the cmd channel (valid/ready); each accepted beat gives exactly one
// result beat on rsp, in order. Operations: record evidence, query receive wait, check
// for a degraded or expired transition, clear. The user writes the three timeout registers
// via write_en/reg_index/write_data only while no command is in flight; not enforced here.
//
// One command can be accepted every cycle while rsp does not stall. The evidence state is
// updated when a command leaves the input register, so the next command in the input
// register already sees it. The receive wait in milliseconds comes out of a six-stage
// long divider, two radix-16 digits per stage, which sets the latency; the state update
// in the first stage sets the throughput.
//
// Reset empties the pipeline, clears the evidence state and loads the timeout registers
// with their default values. When rsp stalls, beats collect in the empty stages, and cmd
// ready drops only when every stage holds a beat.
module clock_evidence_age_watchdog_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              write_en,
	input  logic [1:0]        reg_index,
	input  logic [62:0]       write_data,
	cewd_cmd_if.sink          cmd,
	cewd_rsp_if.source        rsp
);
	import cewd_pkg::*;

	localparam int unsigned ST_S1   = 0;
	localparam int unsigned ST_S2   = 1;
	localparam int unsigned ST_S3   = 2;
	localparam int unsigned ST_DIG0 = 3;
	localparam int unsigned NSTG    = ST_DIG0 + DIV_STAGES + 1;
	localparam int unsigned ST_OUT  = NSTG - 1;

	logic [NSTG-1:0] vld_q, vld_d, take;
	logic [NSTG:0]   rdy;

	// Stage 1: input register.
	op_t                op_s1;
	logic signed [63:0] rep_s1, nam_s1, now_s1;
	logic signed [31:0] cap_s1;

	// Stage 2: decision made, threshold for the divider bypass.
	res_t               res_s2;
	wait_mode_t         wmode_s2;
	logic [30:0]        cap_s2;
	logic [TIME_W-1:0]  now_s2;
	logic [THR_W-1:0]   thr_s2;

	// Stage 3 and the digit stages.
	div_stage_t         stg_s3, stg_d;
	div_stage_t         dig_s4 [DIV_STAGES];
	res_t               rsp_q;
	logic [30:0]        wait_q;
	logic [30:0]        wait_d;

	eval_t              ev;
	logic [30:0]        cap_m1;
	logic [TIME_W-1:0]  diff_m1;
	logic [X_W-1:0]     x_val;
	logic               big;

	always_comb begin
		rdy[NSTG] = rsp.ready;
		for (int i = NSTG - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign take  = {vld_q[NSTG-2:0], cmd.valid} & rdy[NSTG-1:0];
	assign vld_d = take | (vld_q & ~rdy[NSTG:1]);
	assign cmd.ready = rdy[ST_S1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take[ST_S1]) begin
			op_s1  <= op_t'(cmd.operation);
			rep_s1 <= cmd.report_time_ns;
			nam_s1 <= cmd.name_time_ns;
			now_s1 <= cmd.now_ns;
			cap_s1 <= cmd.wait_cap_ms;
		end
	end

	cewd_eval u_eval (
		.clk            (clk),
		.arst_n         (arst_n),
		.write_en       (write_en),
		.reg_index      (reg_index),
		.write_data     (write_data),
		.op             (op_s1),
		.report_time_ns (rep_s1),
		.name_time_ns   (nam_s1),
		.now_ns         (now_s1),
		.wait_cap_ms    (cap_s1),
		.commit         (take[ST_S2]),
		.result         (ev)
	);

	assign cap_m1 = cap_s1[30:0] - 31'd1;

	always_ff @(posedge clk) begin
		if (take[ST_S2]) begin
			res_s2   <= ev.res;
			wmode_s2 <= ev.wmode;
			cap_s2   <= cap_s1[30:0];
			now_s2   <= ev.now;
			thr_s2   <= THR_W'(cap_m1) * THR_W'(DIV_CONST);
		end
	end

	// wait = min(ceil((dl - now) / 1e6), cap); the quotient only matters below cap - 1,
	// which keeps the dividend under THR_W bits.
	always_comb begin
		diff_m1     = res_s2.dl + ~now_s2;
		x_val       = diff_m1[TIME_W-1:DIV_SHIFT];
		big         = x_val >= X_W'(thr_s2);
		stg_d.res   = res_s2;
		stg_d.wmode = (wmode_s2 == WM_DIV && big) ? WM_CAP : wmode_s2;
		stg_d.cap   = cap_s2;
		stg_d.num   = NUM_W'(x_val[THR_W-1:0]);
		stg_d.rem   = '0;
		stg_d.quo   = '0;
	end

	always_ff @(posedge clk) begin
		if (take[ST_S3]) stg_s3 <= stg_d;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_dig
		div_stage_t src, nxt;
		digit_t     d_hi, d_lo;

		if (k == 0) begin : g_first
			assign src = stg_s3;
		end else begin : g_rest
			assign src = dig_s4[k-1];
		end

		always_comb begin
			d_hi     = div_digit(src.rem, src.num[NUM_W-1 -: DIGIT_W]);
			d_lo     = div_digit(d_hi.rem, src.num[NUM_W-DIGIT_W-1 -: DIGIT_W]);
			nxt      = src;
			nxt.num  = {src.num[NUM_W-2*DIGIT_W-1:0], (2*DIGIT_W)'(0)};
			nxt.rem  = d_lo.rem;
			nxt.quo  = {src.quo[QUO_W-2*DIGIT_W-1:0], d_hi.d, d_lo.d};
		end

		always_ff @(posedge clk) begin
			if (take[ST_DIG0+k]) dig_s4[k] <= nxt;
		end
	end

	always_comb begin
		case (dig_s4[DIV_STAGES-1].wmode)
			WM_CAP:  wait_d = dig_s4[DIV_STAGES-1].cap;
			WM_ONE:  wait_d = 31'd1;
			WM_DIV:  wait_d = dig_s4[DIV_STAGES-1].quo[30:0] + 31'd1;
			default: wait_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take[ST_OUT]) begin
			rsp_q  <= dig_s4[DIV_STAGES-1].res;
			wait_q <= wait_d;
		end
	end

	assign rsp.valid          = vld_q[ST_OUT];
	assign rsp.status         = rsp_q.status;
	assign rsp.wait_ms        = wait_q;
	assign rsp.age_event      = rsp_q.age_event;
	assign rsp.deadline_valid = rsp_q.dl_valid;
	assign rsp.deadline_ns    = rsp_q.dl;

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.wait_ms == '0 && rsp.age_event == EV_NONE)
		else $error("error result carries a wait or an event");

	a_no_dl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.deadline_valid |-> rsp.deadline_ns == '0)
		else $error("deadline value without a valid deadline");

	a_exp_no_dl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.age_event == EV_EXPIRED |-> !rsp.deadline_valid)
		else $error("expired clock still reports a deadline");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_S1] && !rdy[ST_S2] |=> vld_q[ST_S1] && $stable(op_s1) && $stable(now_s1))
		else $error("stalled command lost from the input register");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (&vld_q) && !rsp.ready)
		else $error("command refused while the pipeline has room");

endmodule
